FILE: rtl/deq_pkg.sv
// Types and constants used by the double-ended queue top module.
// No dependencies.
package deq_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 3;
  localparam int unsigned StWidth   = 2;
  localparam int unsigned OccWidth  = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST_FWD   = 3'd4,
    OP_LIST_REV   = 3'd5
  } op_e;

  typedef enum logic [StWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OpWidth-1:0]          operation;
    logic signed [DataWidth-1:0] value;
  } deq_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic [StWidth-1:0]          status;
    logic                        last;
    logic [OccWidth-1:0]         occupancy;
  } deq_rsp_t;

endpackage

FILE: rtl/deq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/double_ended_queue_top.sv
// Double-ended queue of signed words held in a ring RAM with a front index and a count.
// Pushes, pops and unknown operations can be issued back to back; each result appears
// in the cycle after the transfer; popped and listed words are the RAM's registered read.
// A list holds busy until its last read and emits one word per cycle, limited by the read
// port. Results cannot be stalled. Reset (rst_ni low, asynchronous) empties the queue.
// Depends on deq_pkg and deq_ram.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  deq_req_t req_i,
  output logic     busy,
  output logic     result_valid_o,
  output deq_rsp_t rsp_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_LIST = 2'b10
  } fsm_e;

  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx, input logic up);
    logic [IW-1:0] res;
    if (up) begin
      res = (idx == IW'(CAPACITY - 1)) ? '0 : idx + IW'(1);
    end else begin
      res = (idx == '0) ? IW'(CAPACITY - 1) : idx - IW'(1);
    end
    return res;
  endfunction

  fsm_e                state_q, state_d;
  logic [IW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       addr_q, addr_d;
  logic [CW-1:0]       left_q, left_d;
  logic                fwd_q, fwd_d;
  logic                valid_q, valid_d;
  logic                from_ram_q, from_ram_d;
  logic [StWidth-1:0]  status_q, status_d;
  logic                last_q, last_d;

  logic                accept;
  logic                is_empty, is_full;
  logic [IW-1:0]       back_idx;
  logic                we, re;
  logic [IW-1:0]       waddr, raddr;
  logic [DataWidth-1:0] rdata;

  assign busy     = (state_q == FSM_LIST);
  assign accept   = start && !busy;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(CAPACITY));
  assign back_idx = ring_pos(front_q, count_q - CW'(1));

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    addr_d     = addr_q;
    left_d     = left_q;
    fwd_d      = fwd_q;
    valid_d    = 1'b0;
    from_ram_d = 1'b0;
    status_d   = ST_OK;
    last_d     = 1'b1;
    we         = 1'b0;
    waddr      = '0;
    re         = 1'b0;
    raddr      = addr_q;

    if (busy) begin
      // Walk the ring one entry per cycle; the word shows up in the next cycle.
      re         = 1'b1;
      valid_d    = 1'b1;
      from_ram_d = 1'b1;
      last_d     = (left_q == CW'(1));
      left_d     = left_q - CW'(1);
      addr_d     = step_idx(addr_q, fwd_q);
      if (left_q == CW'(1)) begin
        state_d = FSM_IDLE;
      end
    end else if (accept) begin
      valid_d = 1'b1;
      case (req_i.operation)
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = ring_pos(front_q, count_q);
            count_d = count_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = step_idx(front_q, 1'b0);
            front_d = step_idx(front_q, 1'b0);
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = front_q;
            from_ram_d = 1'b1;
            front_d    = step_idx(front_q, 1'b1);
            count_d    = count_q - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = back_idx;
            from_ram_d = 1'b1;
            count_d    = count_q - CW'(1);
          end
        end
        OP_LIST_FWD, OP_LIST_REV: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            fwd_d      = (req_i.operation == OP_LIST_FWD);
            re         = 1'b1;
            raddr      = fwd_d ? front_q : back_idx;
            from_ram_d = 1'b1;
            last_d     = (count_q == CW'(1));
            addr_d     = step_idx(raddr, fwd_d);
            left_d     = count_q - CW'(1);
            if (count_q != CW'(1)) begin
              state_d = FSM_LIST;
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      front_q    <= '0;
      count_q    <= '0;
      addr_q     <= '0;
      left_q     <= '0;
      fwd_q      <= 1'b1;
      valid_q    <= 1'b0;
      from_ram_q <= 1'b0;
      status_q   <= ST_OK;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      addr_q     <= addr_d;
      left_q     <= left_d;
      fwd_q      <= fwd_d;
      valid_q    <= valid_d;
      from_ram_q <= from_ram_d;
      status_q   <= status_d;
      last_q     <= last_d;
    end
  end

  deq_ram #(
    .Width(DataWidth),
    .Depth(CAPACITY)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(req_i.value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The count register already holds the occupancy after the operation being reported.
  assign result_valid_o     = valid_q;
  assign rsp_o.result_value = from_ram_q ? rdata : '0;
  assign rsp_o.status       = status_q;
  assign rsp_o.last         = last_q;
  assign rsp_o.occupancy    = OccWidth'(count_q);

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted item produced no result in the next cycle");

  a_list_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && (from_ram_q == 1'b1))
    else $error("list walk skipped a word");

  a_not_last_only_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.last) |-> busy)
    else $error("intermediate result outside a list walk");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("held count exceeds capacity");

endmodule
